// File: design/tbsg_pkg.sv
// ----------------------------------------------------------------------------
// Broadcast schedule generator package
// Shared widths, operation codes, register map, sequencer states and the
// virtual-to-real rank mapping.
// ----------------------------------------------------------------------------
package tbsg_pkg;

  localparam int RankW  = 6;
  localparam int SizeW  = 7;
  localparam int CountW = 31;
  localparam int ProdW  = 12;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  typedef logic [RankW-1:0]  rank_t;
  typedef logic [SizeW-1:0]  size_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [ProdW-1:0]  prod_t;

  // Operation codes carried on the result port
  typedef enum logic [1:0] {
    OP_RECV    = 2'd0,
    OP_BARRIER = 2'd1,
    OP_SEND    = 2'd2
  } op_kind_e;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_GROUP_SIZE = 3'd0;
  localparam logic [2:0] REG_OWN_RANK   = 3'd1;
  localparam logic [2:0] REG_ROOT_RANK  = 3'd2;
  localparam logic [2:0] REG_TREE_KIND  = 3'd3;
  localparam logic [2:0] REG_FANOUT     = 3'd4;

  // Fanout setting that selects a linear (flat) broadcast
  localparam rank_t LINEAR_FANOUT = 6'd10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_KRECV,
    S_BRECV,
    S_BARRIER,
    S_MUL,
    S_KSEND,
    S_BSEND,
    S_FLUSH
  } state_e;

  // Swap virtual rank 0 and the root, keep all other ranks
  function automatic rank_t v_to_rank(input rank_t v, input rank_t root);
    rank_t r;
    r = v;
    if (v == '0) r = root;
    if (v == root) r = '0;
    return r;
  endfunction

endpackage

// File: design/tbsg_alu.sv
// ----------------------------------------------------------------------------
// Shared adder / subtractor
// One add-or-subtract with an unsigned greater-or-equal flag, reused by the
// divide, multiply, receive-search and send steps of the schedule sequencer.
// ----------------------------------------------------------------------------
module tbsg_alu (
  input  tbsg_pkg::prod_t a_i,
  input  tbsg_pkg::prod_t b_i,
  input  logic            sub_i,
  output tbsg_pkg::prod_t sum_o,
  output logic            ge_o
);
  import tbsg_pkg::*;

  logic [ProdW:0] res;

  always_comb begin
    if (sub_i) begin
      res = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      res = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign sum_o = res[ProdW-1:0];
  // No borrow on subtract means a >= b
  assign ge_o  = sub_i & ~res[ProdW];

endmodule

// File: design/tree_broadcast_schedule_gen.sv
// ----------------------------------------------------------------------------
// Tree broadcast schedule generator
// Sequence: a rejected request (zero count or a rank outside the group) goes
//   from setup straight to flush. A k-ary request runs setup, 6 multiply steps,
//   up to 63 sends, one closing send check and flush. A non-root k-ary node
//   adds 6 divide steps, a receive and a barrier, but then sends to at most
//   31 children.
// Throughput: one request at a time; the shared adder does one divide,
//   multiply or search step per cycle, and sends come out at most one per cycle.
// Each operation waits in the lookahead stage until the next one is generated
//   or the request flushes, then passes through the result register; the
//   receiver cannot stall.
// Reset: asynchronous, active low; only the configuration registers, the state and the valid flags are reset.
// ----------------------------------------------------------------------------
module tree_broadcast_schedule_gen #(
  parameter int MAX_NODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel
  input  logic                start,
  output logic                busy,
  input  tbsg_pkg::count_t    element_count_i,
  // Result channel
  output logic                op_valid_o,
  output logic [1:0]          op_kind_o,
  output tbsg_pkg::rank_t     peer_rank_o,
  output tbsg_pkg::count_t    op_elements_o,
  output logic                last_op_o,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tbsg_pkg::*;

  localparam size_t MaxP = SizeW'(MAX_NODES);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  size_t  group_size_q;
  rank_t  own_rank_q;
  rank_t  root_rank_q;
  logic   tree_kind_q;
  rank_t  fanout_q;
  logic   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= 7'd1;
      own_rank_q   <= '0;
      root_rank_q  <= '0;
      tree_kind_q  <= 1'b0;
      fanout_q     <= 6'd2;
    end else if (cfg_wr) begin
      priority case (paddr[4:2])
        REG_GROUP_SIZE: group_size_q <= pwdata[SizeW-1:0];
        REG_OWN_RANK:   own_rank_q   <= pwdata[RankW-1:0];
        REG_ROOT_RANK:  root_rank_q  <= pwdata[RankW-1:0];
        REG_TREE_KIND:  tree_kind_q  <= pwdata[0];
        REG_FANOUT:     fanout_q     <= pwdata[RankW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    priority case (paddr[4:2])
      REG_GROUP_SIZE: prdata = {{(DataW-SizeW){1'b0}}, group_size_q};
      REG_OWN_RANK:   prdata = {{(DataW-RankW){1'b0}}, own_rank_q};
      REG_ROOT_RANK:  prdata = {{(DataW-RankW){1'b0}}, root_rank_q};
      REG_TREE_KIND:  prdata = {{(DataW-1){1'b0}}, tree_kind_q};
      REG_FANOUT:     prdata = {{(DataW-RankW){1'b0}}, fanout_q};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  count_t count_q, count_d;
  size_t  p_q, p_d;           // clamped group size
  rank_t  vrank_q, vrank_d;   // own virtual rank
  rank_t  f_q, f_d;           // effective fanout
  logic [2:0] step_q, step_d; // divide / multiply step, or binomial round
  rank_t  rem_q, rem_d;       // divider remainder
  rank_t  num_q, num_d;       // divider dividend, shifted out MSB first
  rank_t  quo_q, quo_d;       // divider quotient
  prod_t  acc_q, acc_d;       // product, then current child
  prod_t  mcand_q, mcand_d;   // multiplicand, shifted left each step
  rank_t  mplier_q, mplier_d; // multiplier, shifted right each step
  rank_t  left_q, left_d;     // sends still allowed by the fanout

  logic   accept;
  assign accept = start & ~busy;
  assign busy   = (state_q != S_IDLE);

  // Request setup, worked out from the registers in the setup cycle
  size_t  p_c;
  rank_t  vrank_c;
  rank_t  f_c;
  logic   bad_c;

  always_comb begin
    if (group_size_q == '0) begin
      p_c = 7'd1;
    end else if (group_size_q > MaxP) begin
      p_c = MaxP;
    end else begin
      p_c = group_size_q;
    end

    bad_c = (count_q == '0) || ({1'b0, own_rank_q} >= p_c) ||
            ({1'b0, root_rank_q} >= p_c);

    vrank_c = own_rank_q;
    if (own_rank_q == '0) vrank_c = root_rank_q;
    if (own_rank_q == root_rank_q) vrank_c = '0;

    f_c = fanout_q;
    if (fanout_q == LINEAR_FANOUT) begin
      f_c = (p_c > 7'd1) ? RankW'(p_c - 7'd1) : 6'd1;
    end
    if (f_c == '0) f_c = 6'd1;
  end

  // Binomial round weight, 2^round
  size_t pw;
  assign pw = size_t'(1) << step_q;

  // --------------------------------------------------------------------------
  // Shared adder
  // --------------------------------------------------------------------------
  prod_t alu_a, alu_b, alu_sum;
  logic  alu_sub, alu_ge;

  tbsg_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  // Candidate operation from the sequencer
  logic     gen_valid;
  op_kind_e gen_kind;
  rank_t    gen_peer;

  logic brecv_match;
  logic ksend_ok;
  logic bsend_more;
  logic bsend_ok;

  assign brecv_match = (({1'b0, vrank_q} >> step_q) == 7'd1);
  assign ksend_ok    = (left_q != '0) && (alu_sum < prod_t'(p_q));
  assign bsend_more  = (pw < p_q);
  assign bsend_ok    = (vrank_q == '0) ||
                       (({1'b0, vrank_q} < pw) && (alu_sum < prod_t'(p_q)));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SETUP;
      end
      S_SETUP: begin
        if (bad_c) begin
          state_d = S_FLUSH;
        end else if (vrank_c != '0) begin
          state_d = tree_kind_q ? S_DIV : S_BRECV;
        end else begin
          state_d = tree_kind_q ? S_MUL : S_BSEND;
        end
      end
      S_DIV: begin
        if (step_q == 3'd5) state_d = S_KRECV;
      end
      S_KRECV:   state_d = S_BARRIER;
      S_BRECV: begin
        if (brecv_match) state_d = S_BARRIER;
      end
      S_BARRIER: state_d = tree_kind_q ? S_MUL : S_BSEND;
      S_MUL: begin
        if (step_q == 3'd5) state_d = S_KSEND;
      end
      S_KSEND: begin
        if (!ksend_ok) state_d = S_FLUSH;
      end
      S_BSEND: begin
        if (!bsend_more) state_d = S_FLUSH;
      end
      S_FLUSH:   state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: adder operands and candidate operation
  // --------------------------------------------------------------------------
  always_comb begin
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    gen_valid = 1'b0;
    gen_kind  = OP_SEND;
    gen_peer  = '0;
    unique case (state_q)
      S_DIV: begin
        // Shift in the next dividend bit, trial-subtract the fanout
        alu_a   = prod_t'({rem_q, num_q[RankW-1]});
        alu_b   = prod_t'(f_q);
        alu_sub = 1'b1;
      end
      S_KRECV: begin
        gen_valid = 1'b1;
        gen_kind  = OP_RECV;
        gen_peer  = v_to_rank(quo_q, root_rank_q);
      end
      S_BRECV: begin
        // Parent is the virtual rank with its top bit cleared
        alu_a   = prod_t'(vrank_q);
        alu_b   = prod_t'(pw);
        alu_sub = 1'b1;
        if (brecv_match) begin
          gen_valid = 1'b1;
          gen_kind  = OP_RECV;
          gen_peer  = v_to_rank(alu_sum[RankW-1:0], root_rank_q);
        end
      end
      S_BARRIER: begin
        gen_valid = 1'b1;
        gen_kind  = OP_BARRIER;
        gen_peer  = '0;
      end
      S_MUL: begin
        alu_a = acc_q;
        alu_b = mcand_q;
      end
      S_KSEND: begin
        alu_a = acc_q;
        alu_b = prod_t'(1);
        if (ksend_ok) begin
          gen_valid = 1'b1;
          gen_kind  = OP_SEND;
          gen_peer  = v_to_rank(alu_sum[RankW-1:0], root_rank_q);
        end
      end
      S_BSEND: begin
        alu_a = prod_t'(vrank_q);
        alu_b = prod_t'(pw);
        if (bsend_more && bsend_ok) begin
          gen_valid = 1'b1;
          gen_kind  = OP_SEND;
          gen_peer  = v_to_rank(alu_sum[RankW-1:0], root_rank_q);
        end
      end
      S_IDLE, S_SETUP, S_FLUSH: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    count_d  = count_q;
    p_d      = p_q;
    vrank_d  = vrank_q;
    f_d      = f_q;
    step_d   = step_q;
    rem_d    = rem_q;
    num_d    = num_q;
    quo_d    = quo_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    left_d   = left_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) count_d = element_count_i;
      end
      S_SETUP: begin
        p_d      = p_c;
        vrank_d  = vrank_c;
        f_d      = f_c;
        step_d   = '0;
        rem_d    = '0;
        num_d    = vrank_c - 6'd1;
        quo_d    = '0;
        acc_d    = '0;
        mcand_d  = prod_t'(f_c);
        mplier_d = vrank_c;
        left_d   = f_c;
      end
      S_DIV: begin
        rem_d  = alu_ge ? alu_sum[RankW-1:0] : alu_a[RankW-1:0];
        quo_d  = {quo_q[RankW-2:0], alu_ge};
        num_d  = num_q << 1;
        step_d = (step_q == 3'd5) ? 3'd0 : step_q + 3'd1;
      end
      S_BRECV: begin
        step_d = brecv_match ? 3'd0 : step_q + 3'd1;
      end
      S_BARRIER: begin
        step_d = '0;
      end
      S_MUL: begin
        if (mplier_q[0]) acc_d = alu_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = (step_q == 3'd5) ? 3'd0 : step_q + 3'd1;
      end
      S_KSEND: begin
        if (ksend_ok) begin
          acc_d  = alu_sum;
          left_d = left_q - 6'd1;
        end
      end
      S_BSEND: begin
        if (bsend_more) step_d = step_q + 3'd1;
      end
      S_KRECV, S_FLUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    p_q      <= p_d;
    vrank_q  <= vrank_d;
    f_q      <= f_d;
    step_q   <= step_d;
    rem_q    <= rem_d;
    num_q    <= num_d;
    quo_q    <= quo_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    left_q   <= left_d;
  end

  // --------------------------------------------------------------------------
  // Lookahead stage: hold one operation until the next one (or the end of
  // the request) shows whether it is the last.
  // --------------------------------------------------------------------------
  logic     pend_valid_q;
  op_kind_e pend_kind_q;
  rank_t    pend_peer_q;
  logic     out_fire;
  logic     out_last;

  assign out_last = (state_q == S_FLUSH);
  assign out_fire = pend_valid_q & (gen_valid | out_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (gen_valid) begin
      pend_valid_q <= 1'b1;
    end else if (out_last) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_valid) begin
      pend_kind_q <= gen_kind;
      pend_peer_q <= gen_peer;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic     op_valid_q;
  op_kind_e op_kind_q;
  rank_t    peer_q;
  count_t   elems_q;
  logic     last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else begin
      op_valid_q <= out_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      op_kind_q <= pend_kind_q;
      peer_q    <= pend_peer_q;
      elems_q   <= (pend_kind_q == OP_BARRIER) ? '0 : count_q;
      last_q    <= out_last;
    end
  end

  assign op_valid_o    = op_valid_q;
  assign op_kind_o     = op_kind_q;
  assign peer_rank_o   = peer_q;
  assign op_elements_o = elems_q;
  assign last_op_o     = last_q;

endmodule
